// ----- rtl/pps_pkg.sv -----
// Shared types and constants of the preemptive priority scheduler.
// Used by every module of the block; depends on nothing.
package pps_pkg;

   // Default number of ready-queue entries.
   localparam int QUEUE_DEPTH_DEFAULT = 16;

   // Event codes carried in the func field.
   localparam logic FUNC_ARRIVAL  = 1'b0;
   localparam logic FUNC_COMPLETE = 1'b1;

   // One request transaction.
   typedef struct packed {
      logic        func;
      logic [31:0] now_time;
      logic [15:0] new_process_id;
      logic [31:0] new_arrival_time;
      logic [15:0] new_total_burst;
      logic [7:0]  new_priority;
   } req_type;

   // One response transaction.
   typedef struct packed {
      logic        idle;
      logic [15:0] run_process_id;
      logic [31:0] run_arrival_time;
      logic [15:0] run_total_burst;
      logic [31:0] run_start_time;
      logic [31:0] run_end_time;
      logic [15:0] run_remaining_burst;
      logic [7:0]  run_priority;
      logic        dropped;
   } rsp_type;

   // Process record as held in the ready queue and for the runner.
   // Remaining burst always equals total burst when a record is stored,
   // so it is not kept separately.
   typedef struct packed {
      logic [15:0] proc_id;
      logic [31:0] arrival;
      logic [15:0] total_burst;
      logic [7:0]  priority_num;
   } entry_type;

   // Sequencer states.
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DECIDE,
      ST_SCAN,
      ST_DISPATCH,
      ST_SHIFT,
      ST_FINISH
   } state_type;

endpackage

// ----- rtl/pps_queue_ram.sv -----
// Ready-queue storage: one write port and one read port with registered data.
// Depends on pps_pkg for the entry record type.
module pps_queue_ram #(
   parameter int QUEUE_DEPTH = pps_pkg::QUEUE_DEPTH_DEFAULT,
   localparam int ADDR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1
) (
   input  logic                clock,
   input  logic                wr_en,
   input  logic [ADDR_W-1:0]   wr_addr,
   input  pps_pkg::entry_type  wr_data,
   input  logic [ADDR_W-1:0]   rd_addr,
   output pps_pkg::entry_type  rd_data
);

   pps_pkg::entry_type mem [QUEUE_DEPTH];
   pps_pkg::entry_type rd_data_ff;

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Read port, data registered.
   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/pps_ctrl.sv -----
// Scheduling sequencer: runner record, queue count, priority scan and queue compaction.
// Depends on pps_pkg and drives one pps_queue_ram instance.
module pps_ctrl #(
   parameter int QUEUE_DEPTH = pps_pkg::QUEUE_DEPTH_DEFAULT,
   localparam int ADDR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1,
   localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1)
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  pps_pkg::req_type req_data,
   output logic             res_valid,
   output pps_pkg::rsp_type res_data,
   input  logic             out_free
);

   localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(QUEUE_DEPTH);

   pps_pkg::state_type state_ff, state_in;
   pps_pkg::req_type   req_ff, req_in;
   pps_pkg::entry_type cur_ff, cur_in;
   pps_pkg::entry_type best_ff, best_in;
   logic               cur_valid_ff, cur_valid_in;
   logic [31:0]        cur_start_ff, cur_start_in;
   logic [31:0]        cur_end_ff, cur_end_in;
   logic               drop_ff, drop_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic [CNT_W-1:0]   ra_ff, ra_in;
   logic               pend_ff, pend_in;
   logic [ADDR_W-1:0]  pend_idx_ff, pend_idx_in;
   logic [ADDR_W-1:0]  best_idx_ff, best_idx_in;

   logic               mem_wr_en;
   logic [ADDR_W-1:0]  mem_wr_addr;
   pps_pkg::entry_type mem_wr_data;
   logic [ADDR_W-1:0]  mem_rd_addr;
   pps_pkg::entry_type mem_rd_data;

   logic [15:0]        add_total;
   logic [31:0]        end_sum;
   logic [CNT_W-1:0]   count_last;
   pps_pkg::entry_type new_entry;

   pps_queue_ram #(
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   // Shared end-time adder; the sum wraps at 32 bits.
   assign end_sum    = req_ff.now_time + {16'd0, add_total};
   assign count_last = count_ff - CNT_W'(1);

   always_comb begin
      new_entry.proc_id      = req_ff.new_process_id;
      new_entry.arrival      = req_ff.new_arrival_time;
      new_entry.total_burst  = req_ff.new_total_burst;
      new_entry.priority_num = req_ff.new_priority;
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= pps_pkg::ST_IDLE;
         cur_valid_ff <= 1'b0;
         count_ff     <= '0;
         pend_ff      <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cur_valid_ff <= cur_valid_in;
         count_ff     <= count_in;
         pend_ff      <= pend_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      req_ff       <= req_in;
      cur_ff       <= cur_in;
      best_ff      <= best_in;
      cur_start_ff <= cur_start_in;
      cur_end_ff   <= cur_end_in;
      drop_ff      <= drop_in;
      ra_ff        <= ra_in;
      pend_idx_ff  <= pend_idx_in;
      best_idx_ff  <= best_idx_in;
   end

   // Next state, queue accesses and scheduling decisions.
   always_comb begin
      state_in     = state_ff;
      req_in       = req_ff;
      cur_in       = cur_ff;
      best_in      = best_ff;
      cur_valid_in = cur_valid_ff;
      cur_start_in = cur_start_ff;
      cur_end_in   = cur_end_ff;
      drop_in      = drop_ff;
      count_in     = count_ff;
      ra_in        = ra_ff;
      pend_in      = 1'b0;
      pend_idx_in  = pend_idx_ff;
      best_idx_in  = best_idx_ff;
      mem_wr_en    = 1'b0;
      mem_wr_addr  = count_ff[ADDR_W-1:0];
      mem_wr_data  = cur_ff;
      mem_rd_addr  = '0;
      add_total    = req_ff.new_total_burst;
      res_valid    = 1'b0;

      unique case (state_ff)
         pps_pkg::ST_IDLE: begin
            if (req_valid) begin
               req_in   = req_data;
               state_in = pps_pkg::ST_DECIDE;
            end
         end

         pps_pkg::ST_DECIDE: begin
            drop_in = 1'b0;
            if (req_ff.func == pps_pkg::FUNC_ARRIVAL) begin
               state_in = pps_pkg::ST_FINISH;
               priority if (!cur_valid_ff) begin
                  // Nothing runs: the arrival starts at once.
                  cur_in       = new_entry;
                  cur_valid_in = 1'b1;
                  cur_start_in = req_ff.now_time;
                  cur_end_in   = end_sum;
               end else if (count_ff == DEPTH_CNT) begin
                  drop_in = 1'b1;
               end else if (req_ff.new_priority > cur_ff.priority_num) begin
                  // Less urgent arrival waits in the queue.
                  mem_wr_en   = 1'b1;
                  mem_wr_data = new_entry;
                  count_in    = count_ff + CNT_W'(1);
               end else begin
                  // Preemption: the runner goes to the queue tail.
                  mem_wr_en    = 1'b1;
                  mem_wr_data  = cur_ff;
                  count_in     = count_ff + CNT_W'(1);
                  cur_in       = new_entry;
                  cur_start_in = req_ff.now_time;
                  cur_end_in   = end_sum;
               end
            end else begin
               cur_valid_in = 1'b0;
               if (count_ff == '0) begin
                  state_in = pps_pkg::ST_FINISH;
               end else begin
                  mem_rd_addr = '0;
                  pend_in     = 1'b1;
                  pend_idx_in = '0;
                  ra_in       = CNT_W'(1);
                  state_in    = pps_pkg::ST_SCAN;
               end
            end
         end

         pps_pkg::ST_SCAN: begin
            // Stream entries out one per cycle and keep the first lowest number.
            if (ra_ff < count_ff) begin
               mem_rd_addr = ra_ff[ADDR_W-1:0];
               pend_in     = 1'b1;
               pend_idx_in = ra_ff[ADDR_W-1:0];
               ra_in       = ra_ff + CNT_W'(1);
            end
            if (pend_ff) begin
               if ((pend_idx_ff == '0) || (mem_rd_data.priority_num < best_ff.priority_num)) begin
                  best_in     = mem_rd_data;
                  best_idx_in = pend_idx_ff;
               end
               if (CNT_W'(pend_idx_ff) == count_last) begin
                  state_in = pps_pkg::ST_DISPATCH;
               end
            end
         end

         pps_pkg::ST_DISPATCH: begin
            add_total    = best_ff.total_burst;
            cur_in       = best_ff;
            cur_valid_in = 1'b1;
            cur_start_in = req_ff.now_time;
            cur_end_in   = end_sum;
            if (CNT_W'(best_idx_ff) == count_last) begin
               count_in = count_last;
               state_in = pps_pkg::ST_FINISH;
            end else begin
               mem_rd_addr = best_idx_ff + ADDR_W'(1);
               pend_in     = 1'b1;
               pend_idx_in = best_idx_ff + ADDR_W'(1);
               ra_in       = CNT_W'(best_idx_ff) + CNT_W'(2);
               state_in    = pps_pkg::ST_SHIFT;
            end
         end

         pps_pkg::ST_SHIFT: begin
            // Move each entry behind the removed one up by one place.
            if (ra_ff < count_ff) begin
               mem_rd_addr = ra_ff[ADDR_W-1:0];
               pend_in     = 1'b1;
               pend_idx_in = ra_ff[ADDR_W-1:0];
               ra_in       = ra_ff + CNT_W'(1);
            end
            if (pend_ff) begin
               mem_wr_en   = 1'b1;
               mem_wr_addr = pend_idx_ff - ADDR_W'(1);
               mem_wr_data = mem_rd_data;
               if (CNT_W'(pend_idx_ff) == count_last) begin
                  count_in = count_last;
                  state_in = pps_pkg::ST_FINISH;
               end
            end
         end

         pps_pkg::ST_FINISH: begin
            res_valid = 1'b1;
            if (out_free) begin
               state_in = pps_pkg::ST_IDLE;
            end
         end

         default: begin
            state_in = pps_pkg::ST_IDLE;
         end
      endcase
   end

   // Result record; an idle result carries zeros everywhere else.
   always_comb begin
      res_data = '0;
      if (cur_valid_ff) begin
         res_data.run_process_id      = cur_ff.proc_id;
         res_data.run_arrival_time    = cur_ff.arrival;
         res_data.run_total_burst     = cur_ff.total_burst;
         res_data.run_start_time      = cur_start_ff;
         res_data.run_end_time        = cur_end_ff;
         res_data.run_remaining_burst = cur_ff.total_burst;
         res_data.run_priority        = cur_ff.priority_num;
         res_data.dropped             = drop_ff;
      end else begin
         res_data.idle = 1'b1;
      end
   end

   assign req_ready = (state_ff == pps_pkg::ST_IDLE);

endmodule

// ----- rtl/priority_preemptive_scheduler.sv -----
// Preemptive priority scheduler top level: sequencer plus response register.
// Depends on pps_pkg and pps_ctrl (which holds pps_queue_ram).
//
// Every request transaction yields exactly one response transaction that shows
// the process running after the event, or an idle record. One request is
// handled at a time. An arrival passes through a decide state and a finish
// state, which loads the response register, and the sequencer then returns to
// idle before it accepts the next request. A completion with entries queued
// walks the ready queue through its single memory read port: a decide state, a
// scan of the queued entries to find the most urgent one, a dispatch state, then
// a shift of every entry behind the chosen one to close the gap, and a finish
// state to hand over the response. The response register lets the next request
// be accepted while a response waits.
module priority_preemptive_scheduler #(
   parameter int QUEUE_DEPTH = pps_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  pps_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output pps_pkg::rsp_type rsp_data
);

   logic             res_valid;
   pps_pkg::rsp_type res_data;
   logic             out_free;
   logic             rsp_valid_ff, rsp_valid_in;
   pps_pkg::rsp_type rsp_data_ff, rsp_data_in;

   pps_ctrl #(
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .res_valid (res_valid),
      .res_data  (res_data),
      .out_free  (out_free)
   );

   // The response slot frees when empty or when its transaction is taken.
   assign out_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_data_in  = rsp_data_ff;
      if (res_valid && out_free) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = res_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule
